### sv/b58_pkg.sv
// Shared types, constants and the alphabet lookup for the base-58 encoder.
`timescale 1ns / 1ps

package b58_pkg;

  localparam int MAX_BYTES_DEF = 32;

  // Digit count grows as log(256)/log(58), which is about 1.37 digits per byte (1.38 is used).
  localparam int DIGIT_MUL = 138;
  localparam int DIGIT_DIV = 100;

  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int CAP_W   = 7;
  localparam int RADIX   = 58;

  // The running carry never exceeds 256, so one digit plus carry stays below 2^14.
  localparam int CARRY_W = 9;
  localparam int SUM_W   = 14;

  // Reciprocal of 58 scaled by 2^21, exact for every sum below 2^17.
  localparam int          RECIP_W = 16;
  localparam int          RECIP_S = 21;
  localparam logic [15:0] RECIP_M = 16'd36158;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [8*RADIX-1:0] ALPHA_STR =
      "rpshnaf39wBUDNEGHJKLM4PQRST7VWXYZ2bcdeCg65jkm8oFqi1tuvAxyz";

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              too_long;
    logic [CAP_W-1:0]  total_length;
  } out_beat_t;

  // Digit value to ASCII; codes beyond the alphabet map to its first letter.
  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] idx);
    int          pos;
    logic [7:0]  ch;
    pos = 8 * (RADIX - 1 - int'(idx));
    if (int'(idx) >= RADIX) begin
      pos = 8 * (RADIX - 1);
    end
    ch = ALPHA_STR[pos +: 8];
    return ch[CHAR_W-1:0];
  endfunction

endpackage

### sv/b58_divmod.sv
// Shared divide-by-58 unit: quotient by reciprocal multiply, remainder by shift-add.
`timescale 1ns / 1ps

module b58_divmod (
  input  logic [b58_pkg::SUM_W-1:0]   x,
  output logic [b58_pkg::CARRY_W-1:0] q,
  output logic [b58_pkg::DIGIT_W-1:0] r
);
  import b58_pkg::*;

  logic [SUM_W+RECIP_W-1:0] prod;
  logic [SUM_W-1:0]         q_ext;
  logic [SUM_W-1:0]         q_times;
  logic [SUM_W-1:0]         rem;

  assign prod  = (SUM_W+RECIP_W)'(x) * (SUM_W+RECIP_W)'(RECIP_M);
  assign q     = prod[RECIP_S +: CARRY_W];
  assign q_ext = SUM_W'(q);

  // 58 = 32 + 16 + 8 + 2.
  assign q_times = (q_ext << 5) + (q_ext << 4) + (q_ext << 3) + (q_ext << 1);
  assign rem     = x - q_times;
  assign r       = rem[DIGIT_W-1:0];

endmodule

### sv/b58_digit_ram.sv
// Base-58 digit memory with per-entry valid bits so a single clear empties a whole string.
`timescale 1ns / 1ps

module b58_digit_ram #(
  parameter int DEPTH  = 45,
  parameter int ADDR_W = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [b58_pkg::DIGIT_W-1:0]  wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [b58_pkg::DIGIT_W-1:0]  rdata
);
  import b58_pkg::*;

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clear) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // An entry not written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/base58_encoder.sv
// Top level of the base-58 encoder: byte intake, digit fold sequencer and character output.
`timescale 1ns / 1ps

// Bytes arrive most significant first, one per beat, with last_byte on the final one. A
// leading zero byte is only counted; every later byte, up to MAX_BYTES, is folded into
// the digit memory (DIGITS = MAX_BYTES * 138 / 100 + 1 digits, 45 at MAX_BYTES = 32) by
// the single divide-by-58 unit, one digit per cycle, and in_ready stays low meanwhile.
// After the last byte the memory is scanned for the first nonzero digit, each digit
// passing a read state and a check state. Characters then leave, paced by out_ready: one
// per cycle for each leading zero byte, while each significant digit passes a read state
// and a load state for the registered memory read. A string that would not fit cfg_wdata's
// capacity, or that is longer than MAX_BYTES, yields a single beat with too_long set. The
// result register holds the final character while the next string is already being taken in.
module base58_encoder #(
  parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  b58_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output b58_pkg::out_beat_t        out_data,
  input  logic                      cfg_we,
  input  logic [b58_pkg::CAP_W-1:0] cfg_wdata
);
  import b58_pkg::*;

  localparam int DIGITS = MAX_BYTES * DIGIT_MUL / DIGIT_DIV + 1;
  localparam int ADDR_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int IDX_W  = $clog2(DIGITS + 1);
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int LEN_W  = $clog2(MAX_BYTES + DIGITS + 2);
  localparam int CMP_W  = (LEN_W > CAP_W) ? LEN_W : CAP_W;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_FOLD     = 10'b00_0000_0010,
    S_SCAN_RD  = 10'b00_0000_0100,
    S_SCAN_CHK = 10'b00_0000_1000,
    S_DECIDE   = 10'b00_0001_0000,
    S_ZERO     = 10'b00_0010_0000,
    S_DIG_RD   = 10'b00_0100_0000,
    S_DIG_LD   = 10'b00_1000_0000,
    S_REJECT   = 10'b01_0000_0000,
    S_SPARE    = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic [CNT_W-1:0]   zero_run_r, zero_run_nxt;
  logic               seen_r, seen_nxt;
  logic               overrun_r, overrun_nxt;
  logic               last_r, last_nxt;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic [ADDR_W-1:0]  fold_idx_r, fold_idx_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]   first_r, first_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [LEN_W-1:0]   emit_k_r, emit_k_nxt;
  logic [ADDR_W-1:0]  dig_idx_r, dig_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  logic               take;
  logic               slot_free;
  logic               is_last;
  logic               ram_clear, ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [SUM_W-1:0]   fold_sum;
  logic [CARRY_W-1:0] div_q;
  logic [DIGIT_W-1:0] div_r;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign is_last   = (emit_k_r == count_r - LEN_W'(1));
  assign fold_sum  = SUM_W'(carry_r) + {ram_rdata, 8'b0};

  b58_divmod u_div (
    .x (fold_sum),
    .q (div_q),
    .r (div_r)
  );

  b58_digit_ram #(
    .DEPTH  (DIGITS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (ram_clear),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (div_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    byte_cnt_nxt  = byte_cnt_r;
    zero_run_nxt  = zero_run_r;
    seen_nxt      = seen_r;
    overrun_nxt   = overrun_r;
    last_nxt      = last_r;
    carry_nxt     = carry_r;
    fold_idx_nxt  = fold_idx_r;
    scan_idx_nxt  = scan_idx_r;
    first_nxt     = first_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    emit_k_nxt    = emit_k_r;
    dig_idx_nxt   = dig_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_clear     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = fold_idx_r;
    ram_re        = 1'b0;
    ram_raddr     = fold_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          last_nxt     = in_data.last_byte;
          scan_idx_nxt = '0;
          if (byte_cnt_r >= CNT_W'(MAX_BYTES)) begin
            overrun_nxt = 1'b1;
            state_nxt   = in_data.last_byte ? S_SCAN_RD : S_IDLE;
          end else if (!seen_r && in_data.data_byte == '0) begin
            byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
            zero_run_nxt = zero_run_r + CNT_W'(1);
            state_nxt    = in_data.last_byte ? S_SCAN_RD : S_IDLE;
          end else begin
            // Start the walk at the least significant digit.
            byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
            seen_nxt     = 1'b1;
            carry_nxt    = CARRY_W'(in_data.data_byte);
            fold_idx_nxt = ADDR_W'(DIGITS - 1);
            ram_re       = 1'b1;
            ram_raddr    = ADDR_W'(DIGITS - 1);
            state_nxt    = S_FOLD;
          end
        end
      end

      S_FOLD: begin
        ram_we    = 1'b1;
        ram_waddr = fold_idx_r;
        carry_nxt = div_q;
        if (fold_idx_r == '0) begin
          state_nxt = last_r ? S_SCAN_RD : S_IDLE;
        end else begin
          fold_idx_nxt = fold_idx_r - ADDR_W'(1);
          ram_re       = 1'b1;
          ram_raddr    = fold_idx_r - ADDR_W'(1);
        end
      end

      S_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = scan_idx_r[ADDR_W-1:0];
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (ram_rdata != '0 || scan_idx_r == IDX_W'(DIGITS - 1)) begin
          first_nxt = (ram_rdata != '0) ? scan_idx_r : IDX_W'(DIGITS);
          len_nxt   = LEN_W'(zero_run_r) + LEN_W'(DIGITS) - LEN_W'(first_nxt) + LEN_W'(1);
          state_nxt = S_DECIDE;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          state_nxt    = S_SCAN_RD;
        end
      end

      S_DECIDE: begin
        count_nxt   = len_r - LEN_W'(1);
        emit_k_nxt  = '0;
        dig_idx_nxt = first_r[ADDR_W-1:0];
        if (overrun_r || CMP_W'(len_r) > CMP_W'(cap_r)) begin
          state_nxt = S_REJECT;
        end else if (zero_run_r != '0) begin
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_DIG_RD;
        end
      end

      S_ZERO: begin
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.char_code    = b58_char('0);
          out_data_nxt.last_char    = is_last;
          out_data_nxt.too_long     = 1'b0;
          out_data_nxt.total_length = CAP_W'(len_r);
          emit_k_nxt                = emit_k_r + LEN_W'(1);
          if (is_last) begin
            ram_clear = 1'b1;
            state_nxt = S_IDLE;
          end else if (emit_k_r + LEN_W'(1) == LEN_W'(zero_run_r)) begin
            state_nxt = S_DIG_RD;
          end
        end
      end

      S_DIG_RD: begin
        ram_re    = 1'b1;
        ram_raddr = dig_idx_r;
        state_nxt = S_DIG_LD;
      end

      S_DIG_LD: begin
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.char_code    = b58_char(ram_rdata);
          out_data_nxt.last_char    = is_last;
          out_data_nxt.too_long     = 1'b0;
          out_data_nxt.total_length = CAP_W'(len_r);
          emit_k_nxt                = emit_k_r + LEN_W'(1);
          if (is_last) begin
            ram_clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            dig_idx_nxt = dig_idx_r + ADDR_W'(1);
            state_nxt   = S_DIG_RD;
          end
        end
      end

      S_REJECT: begin
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.char_code    = '0;
          out_data_nxt.last_char    = 1'b1;
          out_data_nxt.too_long     = 1'b1;
          out_data_nxt.total_length = '0;
          ram_clear                 = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Once the final beat of a string is loaded, the string state starts over.
    if (ram_clear) begin
      byte_cnt_nxt = '0;
      zero_run_nxt = '0;
      seen_nxt     = 1'b0;
      overrun_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      byte_cnt_r  <= '0;
      zero_run_r  <= '0;
      seen_r      <= 1'b0;
      overrun_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      zero_run_r  <= zero_run_nxt;
      seen_r      <= seen_nxt;
      overrun_r   <= overrun_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    carry_r    <= carry_nxt;
    fold_idx_r <= fold_idx_nxt;
    scan_idx_r <= scan_idx_nxt;
    first_r    <= first_nxt;
    len_r      <= len_nxt;
    count_r    <= count_nxt;
    emit_k_r   <= emit_k_nxt;
    dig_idx_r  <= dig_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/b58_checker.sv
// Port-level assertions for the base-58 encoder and the bind that attaches them.
`timescale 1ns / 1ps

module b58_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input b58_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input b58_pkg::out_beat_t out_data
);
  import b58_pkg::*;

  // A result beat that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed or dropped while stalled");

  // A rejection is a single terminal beat with no character and no length.
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.too_long |->
      out_data.last_char && out_data.char_code == '0 && out_data.total_length == '0)
    else $error("rejection beat has wrong fields");

  // A normal beat always counts at least one character and the terminator.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.too_long |-> out_data.total_length > CAP_W'(1))
    else $error("normal beat with impossible total length");

  // The final byte of a string always leads into the fold or the digit scan, so intake pauses.
  a_last_pauses: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_byte |=> !in_ready)
    else $error("input taken right after the last byte of a string");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind base58_encoder b58_checker u_b58_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/testbench.sv
// Self-checking testbench for base58_encoder with a built-in base-58 predictor.
`timescale 1ns / 1ps

module testbench;
  import b58_pkg::*;

  localparam int MAX_BYTES    = MAX_BYTES_DEF;
  localparam int DIGITS       = MAX_BYTES * DIGIT_MUL / DIGIT_DIV + 1;
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES  = 1500;
  localparam string B58_LETTERS =
      "rpshnaf39wBUDNEGHJKLM4PQRST7VWXYZ2bcdeCg65jkm8oFqi1tuvAxyz";

  typedef enum {FILL_RANDOM, FILL_ZERO_LED, FILL_ALL_ZERO, FILL_ALL_ONES} fill_style_t;
  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_RARE_STALL} rx_pattern_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_beat_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  base58_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state for the string being taken in.
  logic [DIGIT_W-1:0] digits [DIGITS];
  int                 lead_zeros;
  bit                 nonzero_seen;
  int                 bytes_taken;
  bit                 byte_overrun;
  logic [CAP_W-1:0]   capacity = CAP_RESET;

  in_beat_t  pending_bytes[$];
  out_beat_t expected_chars[$];
  int        mismatches = 0;
  int        chars_seen = 0;

  bit        in_beat_done = 1'b0;
  int        gap_left = 0;
  int        burst_left = 1;

  rx_pattern_t rx_pattern = RX_FREE;
  int          pattern_left = 0;
  int          rx_tick = 0;
  int          hold_left = 0;
  bit          hold_request = 1'b0;

  function automatic void start_string();
    foreach (digits[i]) digits[i] = '0;
    lead_zeros   = 0;
    nonzero_seen = 1'b0;
    bytes_taken  = 0;
    byte_overrun = 1'b0;
  endfunction

  // Folds one byte into the digit register and, on the last byte, queues the characters.
  task automatic encode_byte(input in_beat_t beat);
    int         carry;
    int         first;
    int         len;
    int         k;
    logic [7:0] letter;
    out_beat_t  want;
    if (bytes_taken >= MAX_BYTES) begin
      byte_overrun = 1'b1;
    end else begin
      bytes_taken++;
      if (!nonzero_seen && beat.data_byte == '0) begin
        lead_zeros++;
      end else begin
        nonzero_seen = 1'b1;
        carry = int'(beat.data_byte);
        for (k = DIGITS - 1; k >= 0; k--) begin
          carry += int'(digits[k]) << 8;
          digits[k] = DIGIT_W'(carry % RADIX);
          carry /= RADIX;
        end
      end
    end
    if (!beat.last_byte) return;

    first = 0;
    while (first < DIGITS && digits[first] == '0) first++;
    len = lead_zeros + DIGITS - first + 1;
    if (byte_overrun || len > int'(capacity)) begin
      want.char_code    = '0;
      want.last_char    = 1'b1;
      want.too_long     = 1'b1;
      want.total_length = '0;
      expected_chars.push_back(want);
    end else begin
      for (k = 0; k < len - 1; k++) begin
        if (k < lead_zeros) begin
          letter = B58_LETTERS[0];
        end else begin
          letter = B58_LETTERS[int'(digits[first + k - lead_zeros])];
        end
        want.char_code    = letter[CHAR_W-1:0];
        want.last_char    = (k == len - 2);
        want.too_long     = 1'b0;
        want.total_length = CAP_W'(len);
        expected_chars.push_back(want);
      end
    end
    start_string();
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("MISMATCH %s at output beat %0d: got %0d, expected %0d",
               what, chars_seen, got, want);
    end
  endtask

  task automatic check_char(input out_beat_t got);
    out_beat_t want;
    if (expected_chars.size() == 0) begin
      flag_mismatch("beat with nothing outstanding", int'(got), 0);
    end else begin
      want = expected_chars.pop_front();
      if (got.char_code != want.char_code)
        flag_mismatch("char_code", int'(got.char_code), int'(want.char_code));
      if (got.last_char != want.last_char)
        flag_mismatch("last_char", int'(got.last_char), int'(want.last_char));
      if (got.too_long != want.too_long)
        flag_mismatch("too_long", int'(got.too_long), int'(want.too_long));
      if (got.total_length != want.total_length)
        flag_mismatch("total_length", int'(got.total_length), int'(want.total_length));
    end
    chars_seen++;
  endtask

  // Monitor: both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        encode_byte(in_data);
        in_beat_done = 1'b1;
      end
      if (out_valid && out_ready) begin
        check_char(out_data);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 50);
    return $urandom_range(51, 120);
  endfunction

  // Driver: offers pending bytes in bursts, holding each beat until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_done) begin
      in_beat_done = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_data  <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
          gap_left   = pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall patterns, with one long hold-off on request.
  always @(negedge clk) begin
    rx_tick++;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 200);
      end
      pattern_left--;
      case (rx_pattern)
        RX_FREE:       out_ready <= 1'b1;
        RX_COIN:       out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:     out_ready <= (rx_tick % 4 == 0);
        RX_RARE_STALL: out_ready <= ($urandom_range(0, 9) != 0);
        default:       out_ready <= 1'b1;
      endcase
    end
  end

  task automatic add_beat(input logic [7:0] value, input bit last);
    in_beat_t beat;
    beat.data_byte = value;
    beat.last_byte = last;
    pending_bytes.push_back(beat);
  endtask

  task automatic queue_string(input int n, input fill_style_t style);
    int         i;
    int         lead;
    logic [7:0] value;
    lead = $urandom_range(1, n);
    for (i = 0; i < n; i++) begin
      case (style)
        FILL_ZERO_LED: value = (i < lead) ? 8'h00 : 8'($urandom_range(0, 255));
        FILL_ALL_ZERO: value = 8'h00;
        FILL_ALL_ONES: value = 8'hFF;
        default:       value = 8'($urandom_range(0, 255));
      endcase
      add_beat(value, i == n - 1);
    end
  endtask

  // Mostly short strings, some long ones, and now and then one past MAX_BYTES.
  task automatic queue_random_strings(input int budget);
    int          used;
    int          n;
    int          r;
    fill_style_t style;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55)      n = $urandom_range(1, 6);
      else if (r < 80) n = $urandom_range(7, 20);
      else if (r < 92) n = $urandom_range(21, MAX_BYTES);
      else if (r < 96) n = MAX_BYTES;
      else             n = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
      r = $urandom_range(0, 99);
      if (r < 60)      style = FILL_RANDOM;
      else if (r < 80) style = FILL_ZERO_LED;
      else if (r < 90) style = FILL_ALL_ZERO;
      else             style = FILL_ALL_ONES;
      queue_string(n, style);
      used += n;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    capacity   = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    start_string();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Short strings at the reset capacity: byte extremes, one- and two-digit values,
    // zero runs, and zeros that follow a nonzero byte.
    add_beat(8'h00, 1'b1);
    add_beat(8'hFF, 1'b1);
    add_beat(8'h01, 1'b1);
    add_beat(8'h39, 1'b1);
    add_beat(8'h3A, 1'b1);
    add_beat(8'h00, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h00, 1'b1);
    add_beat(8'h00, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h01, 1'b1);
    add_beat(8'h80, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h00, 1'b1);
    repeat (3) add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b1);
    wait_idle();

    // No room at all: every string is rejected.
    write_capacity('0);
    queue_random_strings(15);
    wait_idle();

    // Widest register value, with the longest strings and an overrun.
    write_capacity('1);
    queue_string(MAX_BYTES, FILL_ALL_ONES);
    queue_string(MAX_BYTES, FILL_ALL_ZERO);
    queue_string(MAX_BYTES + 1, FILL_RANDOM);
    queue_random_strings(30);
    wait_idle();

    write_capacity(CAP_W'($urandom_range(1, 12)));
    queue_random_strings(25);
    wait_idle();

    // The receiver holds off while the sender keeps offering, so the block backs up.
    write_capacity(CAP_RESET);
    queue_random_strings(50);
    hold_request = 1'b1;
    wait_idle();

    write_capacity(CAP_W'($urandom_range(20, 63)));
    queue_random_strings(30);
    wait_idle();

    if (mismatches == 0) begin
      $display("base58_encoder verification clean");
    end else begin
      $display("base58_encoder verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("base58_encoder verification failed");
    $finish;
  end

endmodule

### base58_encoder.f
sv/b58_pkg.sv
sv/b58_divmod.sv
sv/b58_digit_ram.sv
sv/base58_encoder.sv
sv/b58_checker.sv
tb/testbench.sv
